// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked outside reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// property checked at every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/tspuf_pkg.sv =====
// shared constants and the side_cap helper for the torus percolation union-find block
// no dependencies
package tspuf_pkg;

  localparam int SITE_W        = 16;
  localparam int SIZE_W        = 17;
  localparam int SIDE_W        = 9;
  localparam int CNT_W         = 17;
  localparam int SIDE_LIMIT    = 256;
  localparam int SIDE_RESET    = 256;
  localparam int SITE_SPACE    = 65536;
  localparam int DEF_MAX_SITES = 65536;
  localparam int NEIGHBOURS    = 4;

  // neighbour directions
  localparam logic [1:0] DIR_DOWN  = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_RIGHT = 2'd2;
  localparam logic [1:0] DIR_LEFT  = 2'd3;

  // largest side whose square fits in the table, evaluated at elaboration
  function automatic int side_cap(input int max_sites);
    int cap;
    cap = 2;
    for (int i = 0; i < SIDE_LIMIT; i++) begin
      if (cap < SIDE_LIMIT && (cap + 1) * (cap + 1) <= max_sites) begin
        cap = cap + 1;
      end
    end
    return cap;
  endfunction

endpackage

// ===== hw/rtl/tspuf_ram.sv =====
// single-clock table memory: one write port, one read port, registered read
// depends on nothing
module tspuf_ram #(
  parameter int AW    = 16,
  parameter int DW    = 19,
  parameter int DEPTH = 65536
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic [AW-1:0] ra,
  output logic [DW-1:0] rd
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd <= mem[ra];
  end

endmodule

// ===== hw/rtl/torus_site_percolation_union_find.sv =====
// top level of the torus site percolation union-find block
// depends on tspuf_pkg and tspuf_ram
//
// Each item occupies one lattice site and merges it with its occupied
// neighbours in a union-find table held in one memory (one read, one write
// per cycle, registered read). An item passes through acceptance and check
// (a rejected item then goes straight to the result), a restoring division
// that splits the index into row and column, and a neighbour loop; for each
// occupied neighbour the roots of the site and of the neighbour are searched
// with path compression, then joined by size where they differ. The result
// then waits until the previous result has been taken.
// After reset and after each item marked as the last of a run the table is
// swept clean, one entry per cycle, over all its entries (65536 by default);
// no item is taken meanwhile.
module torus_site_percolation_union_find
  import tspuf_pkg::*;
#(
  parameter int MAX_SITES = DEF_MAX_SITES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIDE_W-1:0] cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [SITE_W-1:0] site_index,
  input  logic              last_site,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [SIZE_W-1:0] largest_size,
  output logic [SITE_W-1:0] largest_root,
  output logic              rejected,
  output logic              run_done
);

  localparam int DEPTH = (MAX_SITES < SITE_SPACE) ? MAX_SITES : SITE_SPACE;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = $clog2(DEPTH + 1);
  localparam int DW    = LW + 2;
  localparam int CAP   = side_cap(MAX_SITES);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_DIV, S_NB_ISSUE, S_NB_CHECK,
    S_WALK, S_COMPRESS, S_JOIN, S_LINK, S_RESP
  } state_t;

  state_t            state;
  logic [SIDE_W-1:0] side;
  logic [CNT_W-1:0]  count;
  logic [SITE_W-1:0] site;
  logic              last;
  logic              rej;
  logic [7:0]        row;
  logic [SITE_W-1:0] rem;
  logic [2:0]        bitk;
  logic [2:0]        nb_cnt;
  logic [AW-1:0]     nb;
  logic [AW-1:0]     cur;
  logic [AW-1:0]     root;
  logic [LW-1:0]     size_tmp;
  logic [AW-1:0]     r1;
  logic [LW-1:0]     s1;
  logic              which;
  logic [AW-1:0]     big;
  logic [AW-1:0]     small_r;
  logic [LW-1:0]     sum;
  logic [LW-1:0]     best_size;
  logic [AW-1:0]     best_root;
  logic [AW-1:0]     clr_addr;

  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  logic [DW-1:0]     mem_wd;
  logic [AW-1:0]     mem_ra;
  logic [DW-1:0]     rd;

  logic              rd_used;
  logic              rd_root;
  logic [LW-1:0]     rd_link;
  logic              rej_now;
  logic              cmp_done;
  logic [LW-1:0]     sum_next;
  logic [AW-1:0]     big_next;
  logic [AW-1:0]     small_next;
  logic [CNT_W-1:0]  trial;
  logic [CNT_W-1:0]  divisor;
  logic [CNT_W-1:0]  nb_calc;
  logic [CNT_W-1:0]  s17;
  logic [CNT_W-1:0]  n17;
  logic [SIDE_W-1:0] side_next;

  tspuf_ram #(.AW(AW), .DW(DW), .DEPTH(DEPTH)) u_ram (
    .clk (clk),
    .we  (mem_we),
    .wa  (mem_wa),
    .wd  (mem_wd),
    .ra  (mem_ra),
    .rd  (rd)
  );

  // table entry fields
  assign rd_used  = rd[LW+1];
  assign rd_root  = rd[LW];
  assign rd_link  = rd[LW-1:0];
  assign rej_now  = ({1'b0, site} >= count) || rd_used;
  assign cmp_done = (cur == root) || rd_root;

  // union by size, ties keep the new site's root
  assign sum_next   = r1 == root ? s1 : s1 + size_tmp;
  assign big_next   = (s1 < size_tmp) ? root : r1;
  assign small_next = (s1 < size_tmp) ? r1 : root;

  // one restoring division step
  assign divisor = {{(CNT_W-SIDE_W){1'b0}}, side} << bitk;
  assign trial   = {1'b0, rem} - divisor;

  // wrapped neighbour index
  assign s17 = {1'b0, site};
  assign n17 = {{(CNT_W-SIDE_W){1'b0}}, side};
  always_comb begin
    nb_calc = '0;
    case (nb_cnt[1:0])
      DIR_DOWN:  nb_calc = ({1'b0, row} != side - 1'b1) ? s17 + n17
                                                          : {1'b0, rem};
      DIR_UP:    nb_calc = (row != 8'd0) ? s17 - n17
                                         : {1'b0, rem} + count - n17;
      DIR_RIGHT: nb_calc = (rem[SIDE_W-1:0] != side - 1'b1) ? s17 + 1'b1
                                                             : s17 - n17 + 1'b1;
      DIR_LEFT:  nb_calc = (rem != '0) ? s17 - 1'b1 : s17 + n17 - 1'b1;
      default:   nb_calc = '0;
    endcase
  end

  // side clamped into the supported range
  always_comb begin
    side_next = cfg_wr_data;
    if (cfg_wr_data < SIDE_W'(2)) begin
      side_next = SIDE_W'(2);
    end else if (cfg_wr_data > SIDE_W'(CAP)) begin
      side_next = SIDE_W'(CAP);
    end
  end

  // memory port control
  always_comb begin
    mem_ra = cur;
    mem_we = 1'b0;
    mem_wa = cur;
    mem_wd = '0;
    unique case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr;
      end
      S_IDLE: mem_ra = site_index[AW-1:0];
      S_CHECK: begin
        mem_wa = site[AW-1:0];
        mem_wd = {1'b1, 1'b1, LW'(1)};
        mem_we = !rej_now;
      end
      S_NB_ISSUE: mem_ra = nb_calc[AW-1:0];
      S_NB_CHECK: mem_ra = site[AW-1:0];
      S_WALK: mem_ra = rd_root ? (which ? nb : site[AW-1:0]) : rd_link[AW-1:0];
      S_COMPRESS: begin
        if (cmp_done) begin
          mem_ra = nb;
        end else begin
          mem_ra = rd_link[AW-1:0];
          mem_we = 1'b1;
          mem_wd = {1'b1, 1'b0, LW'(root)};
        end
      end
      S_JOIN: begin
        mem_we = (r1 != root);
        mem_wa = big_next;
        mem_wd = {1'b1, 1'b1, sum_next};
      end
      S_LINK: begin
        mem_we = 1'b1;
        mem_wa = small_r;
        mem_wd = {1'b1, 1'b0, LW'(big)};
      end
      S_DIV, S_RESP: mem_ra = cur;
      default: mem_ra = cur;
    endcase
  end

  assign in_ready = (state == S_IDLE);

  // sequencer, configuration and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      side      <= SIDE_W'(CAP < SIDE_RESET ? CAP : SIDE_RESET);
      count     <= '0;
      best_size <= '0;
      best_root <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        side <= side_next;
      end
      count <= n17 * n17;
      if (out_valid && out_ready && state != S_RESP) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            site  <= site_index;
            last  <= last_site;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          rej <= rej_now;
          rem  <= site;
          row  <= '0;
          bitk <= 3'd7;
          state <= rej_now ? S_RESP : S_DIV;
        end
        S_DIV: begin
          if (!trial[CNT_W-1]) begin
            rem       <= trial[SITE_W-1:0];
            row[bitk] <= 1'b1;
          end
          bitk <= bitk - 1'b1;
          if (bitk == 3'd0) begin
            nb_cnt <= '0;
            state  <= S_NB_ISSUE;
          end
        end
        S_NB_ISSUE: begin
          if (nb_cnt == 3'(NEIGHBOURS)) begin
            state <= S_RESP;
          end else begin
            nb     <= nb_calc[AW-1:0];
            nb_cnt <= nb_cnt + 1'b1;
            state  <= S_NB_CHECK;
          end
        end
        S_NB_CHECK: begin
          if (rd_used) begin
            cur   <= site[AW-1:0];
            which <= 1'b0;
            state <= S_WALK;
          end else begin
            state <= S_NB_ISSUE;
          end
        end
        S_WALK: begin
          if (rd_root) begin
            root     <= cur;
            size_tmp <= rd_link;
            cur      <= which ? nb : site[AW-1:0];
            state    <= S_COMPRESS;
          end else begin
            cur <= rd_link[AW-1:0];
          end
        end
        S_COMPRESS: begin
          if (cmp_done) begin
            if (!which) begin
              r1    <= root;
              s1    <= size_tmp;
              which <= 1'b1;
              cur   <= nb;
              state <= S_WALK;
            end else begin
              state <= S_JOIN;
            end
          end else begin
            cur <= rd_link[AW-1:0];
          end
        end
        S_JOIN: begin
          big     <= big_next;
          small_r <= small_next;
          sum     <= sum_next;
          state   <= (r1 == root) ? S_NB_ISSUE : S_LINK;
        end
        S_LINK: begin
          if (sum > best_size) begin
            best_size <= sum;
            best_root <= big;
          end
          state <= S_NB_ISSUE;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            largest_size <= SIZE_W'(best_size);
            largest_root <= SITE_W'(best_root);
            rejected     <= rej;
            run_done     <= last;
            if (last) begin
              best_size <= '0;
              best_root <= '0;
              clr_addr  <= '0;
              state     <= S_CLEAR;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/tspuf_chk.sv =====
// port-level checker for the torus percolation union-find block, with bind
// depends on tspuf_pkg and assert_macros.svh
`include "assert_macros.svh"

module tspuf_chk
  import tspuf_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [SIZE_W-1:0] largest_size,
  input logic [SITE_W-1:0] largest_root
);

  // a stalled result stays offered
  `ASSERT_CLK(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid)
  // the table sweep after reset holds off items
  `ASSERT_ALWAYS(a_rst_busy, clk, rst |=> !in_ready)
  // one item at a time
  `ASSERT_CLK(a_one_item, clk, rst, in_valid && in_ready |=> !in_ready)
  // no join yet means no root reported
  `ASSERT_CLK(a_empty_root, clk, rst, out_valid && largest_size == '0 |-> largest_root == '0)

endmodule

bind torus_site_percolation_union_find tspuf_chk u_tspuf_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .largest_size (largest_size),
  .largest_root (largest_root)
);
